// ----- rtl/bs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter package
// Shared widths, register indexes, controller states and the key ordering map.
// ----------------------------------------------------------------------------
package bs_pkg;

   localparam int LOG_MAX_KEYS_DEF = 6;
   localparam int KEY_W            = 32;

   // Configuration registers
   localparam int LOG_LEN_W  = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_LOG_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DESCENDING = 1'b1;

   localparam logic [LOG_LEN_W-1:0] LOG_LENGTH_RST = 3'd6;

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_SORT  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   // Order-preserving float-to-unsigned map: invert negatives, flip sign of the rest.
   function automatic logic [KEY_W-1:0] order_map(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] sign_bit;
      sign_bit  = {1'b1, {(KEY_W-1){1'b0}}};
      order_map = k[KEY_W-1] ? ~k : (k ^ sign_bit);
   endfunction

endpackage

// ----- rtl/bs_key_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter key store
// Two single-port-read, single-port-write banks. A key lives in the bank given
// by the parity of its address, so the two keys of any compare pair (addresses
// differing in one bit) always sit in different banks and move together.
// ----------------------------------------------------------------------------
module bs_key_store #(
   parameter int LOG_MAX_KEYS = bs_pkg::LOG_MAX_KEYS_DEF
) (
   input  logic                      clock,
   input  logic [LOG_MAX_KEYS-1:0]   rd_a_addr,
   input  logic [LOG_MAX_KEYS-1:0]   rd_b_addr,
   output logic [bs_pkg::KEY_W-1:0]  rd_a_data,
   output logic [bs_pkg::KEY_W-1:0]  rd_b_data,
   input  logic                      wr_a_en,
   input  logic [LOG_MAX_KEYS-1:0]   wr_a_addr,
   input  logic [bs_pkg::KEY_W-1:0]  wr_a_data,
   input  logic                      wr_b_en,
   input  logic [LOG_MAX_KEYS-1:0]   wr_b_addr,
   input  logic [bs_pkg::KEY_W-1:0]  wr_b_data
);
   import bs_pkg::*;

   localparam int ROWS  = 2 ** (LOG_MAX_KEYS - 1);
   localparam int ROW_W = (LOG_MAX_KEYS > 1) ? LOG_MAX_KEYS - 1 : 1;

   logic [KEY_W-1:0] bank0_mem [ROWS];
   logic [KEY_W-1:0] bank1_mem [ROWS];

   logic [KEY_W-1:0] q0_ff;
   logic [KEY_W-1:0] q1_ff;
   logic             a_bank_ff;

   logic             a_bank;
   logic [ROW_W-1:0] rd0_row;
   logic [ROW_W-1:0] rd1_row;
   logic             wa0;
   logic             wa1;
   logic             wr0_en;
   logic             wr1_en;
   logic [ROW_W-1:0] wr0_row;
   logic [ROW_W-1:0] wr1_row;
   logic [KEY_W-1:0] wr0_data;
   logic [KEY_W-1:0] wr1_data;

   function automatic logic bank_of(input logic [LOG_MAX_KEYS-1:0] addr);
      bank_of = ^addr;
   endfunction

   function automatic logic [ROW_W-1:0] row_of(input logic [LOG_MAX_KEYS-1:0] addr);
      row_of = ROW_W'(addr >> 1);
   endfunction

   // Port A has priority on its bank; port B gets the other one.
   assign a_bank  = bank_of(rd_a_addr);
   assign rd0_row = a_bank ? row_of(rd_b_addr) : row_of(rd_a_addr);
   assign rd1_row = a_bank ? row_of(rd_a_addr) : row_of(rd_b_addr);

   assign wa0      = wr_a_en && !bank_of(wr_a_addr);
   assign wa1      = wr_a_en &&  bank_of(wr_a_addr);
   assign wr0_en   = wa0 || (wr_b_en && !bank_of(wr_b_addr));
   assign wr1_en   = wa1 || (wr_b_en &&  bank_of(wr_b_addr));
   assign wr0_row  = wa0 ? row_of(wr_a_addr) : row_of(wr_b_addr);
   assign wr1_row  = wa1 ? row_of(wr_a_addr) : row_of(wr_b_addr);
   assign wr0_data = wa0 ? wr_a_data : wr_b_data;
   assign wr1_data = wa1 ? wr_a_data : wr_b_data;

   always_ff @(posedge clock) begin
      if (wr0_en) begin
         bank0_mem[wr0_row] <= wr0_data;
      end
      q0_ff <= bank0_mem[rd0_row];
   end

   always_ff @(posedge clock) begin
      if (wr1_en) begin
         bank1_mem[wr1_row] <= wr1_data;
      end
      q1_ff <= bank1_mem[rd1_row];
   end

   always_ff @(posedge clock) begin
      a_bank_ff <= a_bank;
   end

   assign rd_a_data = a_bank_ff ? q1_ff : q0_ff;
   assign rd_b_data = a_bank_ff ? q0_ff : q1_ff;

endmodule

// ----- rtl/bitonic_sorter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter
// Loads 2^L keys, sorts them with the bitonic network on a banked key store
// (one compare-exchange per cycle, paused between network stages while the
// store write-back drains) and streams them out in the chosen order.
// Load: one key per cycle. Sort: L*(L+1)/2 network stages of 2^(L-1) compare
// pairs, each stage followed by a drain state for the store write-back.
// Emit: a key is read from the store only when no earlier read is pending and
// the output register is free or being taken, so reads do not overlap.
// Reset clears the controller and load count; log_length returns to 6 and
// descending to 0. Store contents are not cleared.
// ----------------------------------------------------------------------------
module bitonic_sorter_top #(
   parameter int LOG_MAX_KEYS = bs_pkg::LOG_MAX_KEYS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bs_pkg::KEY_W-1:0]       req_key,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bs_pkg::KEY_W-1:0]       rsp_sorted_key,
   output logic                           rsp_last,
   input  logic                           csr_we,
   input  logic [bs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bs_pkg::*;

   localparam int ADDR_W = LOG_MAX_KEYS;
   localparam int CNT_W  = LOG_MAX_KEYS + 1;
   localparam int LW     = $clog2(LOG_MAX_KEYS + 1);

   state_type state_ff, state_in;

   logic [LOG_LEN_W-1:0] log_length_ff;
   logic                 descending_ff;

   logic [CNT_W-1:0]  load_count_ff, load_count_in;
   logic [LW-1:0]     k_log_ff, k_log_in;
   logic [LW-1:0]     j_log_ff, j_log_in;
   logic [ADDR_W-1:0] pair_ff, pair_in;
   logic              sort_done_ff, sort_done_in;
   logic [CNT_W-1:0]  emit_idx_ff, emit_idx_in;

   logic              cmp_valid_ff;
   logic [ADDR_W-1:0] cmp_a_ff;
   logic [ADDR_W-1:0] cmp_b_ff;
   logic              cmp_up_ff;

   logic              rd_pend_ff;
   logic              rd_last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]  rsp_key_ff;
   logic              rsp_last_ff;

   logic [LW-1:0]     lg;
   logic [CNT_W-1:0]  n_len;
   logic [CNT_W-1:0]  n_last;
   logic [ADDR_W-1:0] half_last;
   logic [ADDR_W-1:0] low_mask;
   logic [ADDR_W-1:0] pair_a;
   logic [ADDR_W-1:0] pair_b;
   logic              pair_up;
   logic              req_acc;
   logic              emit_issue;
   logic              cmp_swap;

   logic [KEY_W-1:0]  rd_a_data;
   logic [KEY_W-1:0]  rd_b_data;
   logic [ADDR_W-1:0] rd_a_addr;
   logic              wr_a_en;
   logic [ADDR_W-1:0] wr_a_addr;
   logic [KEY_W-1:0]  wr_a_data;

   // Run length, clamped to the store size
   assign lg        = (int'(log_length_ff) > LOG_MAX_KEYS) ? LW'(LOG_MAX_KEYS)
                                                           : LW'(log_length_ff);
   assign n_len     = CNT_W'(1) << lg;
   assign n_last    = n_len - CNT_W'(1);
   assign half_last = ADDR_W'((n_len >> 1) - CNT_W'(1));

   // Pair p of a stage at distance 2^j: insert a zero at bit j, partner sets it.
   assign low_mask = (ADDR_W'(1) << j_log_ff) - ADDR_W'(1);
   assign pair_a   = ((pair_ff & ~low_mask) << 1) | (pair_ff & low_mask);
   assign pair_b   = pair_a | (ADDR_W'(1) << j_log_ff);
   assign pair_up  = (k_log_ff == lg) ? !descending_ff
                                      : (((pair_a >> k_log_ff) & ADDR_W'(1)) == '0);

   assign req_ready  = (state_ff == ST_LOAD);
   assign req_acc    = req_valid && req_ready;
   assign emit_issue = (state_ff == ST_EMIT) && !rd_pend_ff && (!rsp_valid_ff || rsp_ready);

   // Equal keys never swap in ascending pairs; in descending pairs they do
   assign cmp_swap = ((order_map(rd_a_data) > order_map(rd_b_data)) == cmp_up_ff);

   assign rd_a_addr = (state_ff == ST_SORT) ? pair_a : emit_idx_ff[ADDR_W-1:0];
   assign wr_a_en   = req_acc || (cmp_valid_ff && cmp_swap);
   assign wr_a_addr = req_acc ? load_count_ff[ADDR_W-1:0] : cmp_a_ff;
   assign wr_a_data = req_acc ? req_key : rd_b_data;

   bs_key_store #(
      .LOG_MAX_KEYS (LOG_MAX_KEYS)
   ) u_store (
      .clock     (clock),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (pair_b),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .wr_a_en   (wr_a_en),
      .wr_a_addr (wr_a_addr),
      .wr_a_data (wr_a_data),
      .wr_b_en   (cmp_valid_ff && cmp_swap),
      .wr_b_addr (cmp_b_ff),
      .wr_b_data (rd_a_data)
   );

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      k_log_in      = k_log_ff;
      j_log_in      = j_log_ff;
      pair_in       = pair_ff;
      sort_done_in  = sort_done_ff;
      emit_idx_in   = emit_idx_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (load_count_ff == n_last) begin
                  load_count_in = '0;
                  k_log_in      = LW'(1);
                  j_log_in      = '0;
                  pair_in       = '0;
                  sort_done_in  = 1'b0;
                  state_in      = (lg == '0) ? ST_EMIT : ST_SORT;
               end else begin
                  load_count_in = load_count_ff + CNT_W'(1);
               end
            end
         end
         ST_SORT: begin
            if (pair_ff == half_last) begin
               pair_in  = '0;
               state_in = ST_DRAIN;
               if (j_log_ff == '0) begin
                  if (k_log_ff == lg) begin
                     sort_done_in = 1'b1;
                  end else begin
                     k_log_in = k_log_ff + LW'(1);
                     j_log_in = k_log_ff;
                  end
               end else begin
                  j_log_in = j_log_ff - LW'(1);
               end
            end else begin
               pair_in = pair_ff + ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            // lets the last write-back of the stage land
            state_in     = sort_done_ff ? ST_EMIT : ST_SORT;
            sort_done_in = 1'b0;
         end
         ST_EMIT: begin
            if (emit_issue) begin
               if (emit_idx_ff == n_last) begin
                  emit_idx_in = '0;
                  state_in    = ST_LOAD;
               end else begin
                  emit_idx_in = emit_idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      // A new length drops any partial load
      if (csr_we && (csr_index == CSR_LOG_LENGTH)) begin
         load_count_in = '0;
      end
   end

   always_comb begin
      if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
         k_log_ff      <= '0;
         j_log_ff      <= '0;
         pair_ff       <= '0;
         sort_done_ff  <= 1'b0;
         emit_idx_ff   <= '0;
         cmp_valid_ff  <= 1'b0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         log_length_ff <= LOG_LENGTH_RST;
         descending_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         k_log_ff      <= k_log_in;
         j_log_ff      <= j_log_in;
         pair_ff       <= pair_in;
         sort_done_ff  <= sort_done_in;
         emit_idx_ff   <= emit_idx_in;
         cmp_valid_ff  <= (state_ff == ST_SORT);
         rd_pend_ff    <= emit_issue;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LOG_LENGTH: log_length_ff <= csr_wdata[LOG_LEN_W-1:0];
               CSR_DESCENDING: descending_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmp_a_ff   <= pair_a;
      cmp_b_ff   <= pair_b;
      cmp_up_ff  <= pair_up;
      rd_last_ff <= (emit_idx_ff == n_last);
      if (rd_pend_ff) begin
         rsp_key_ff  <= rd_a_data;
         rsp_last_ff <= rd_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sorted_key = rsp_key_ff;
   assign rsp_last       = rsp_last_ff;

   // Read data must never land on a result that is still waiting
   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !(rsp_valid_ff && !rsp_ready))
      else $error("store read lands on an occupied output register");

   // Both keys of a pair must come from different banks
   a_pair_banks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT) |-> ((^pair_a) != (^pair_b)))
      else $error("compare pair maps to a single bank");

   // Load pointer stays inside the run while loading
   a_load_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (load_count_ff < n_len))
      else $error("load count beyond run length");

   // A read of the final entry must go out with the last flag set
   a_last_source: assert property (@(posedge clock) disable iff (reset)
      (rd_pend_ff && rd_last_ff) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final key not marked last");

endmodule
